[hdl/sorted_range_address_translator_defines.svh]
// Assertion macros for the segment translator RTL (used by the datapath, srat_dp).
// Relies on clk and rst being in scope where used.
`ifndef SORTED_RANGE_ADDRESS_TRANSLATOR_DEFINES_SVH
`define SORTED_RANGE_ADDRESS_TRANSLATOR_DEFINES_SVH

// same-cycle implication
`define SRAT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srat assertion failed");

// next-cycle implication
`define SRAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srat assertion failed");

`endif

[hdl/srat_pkg.sv]
// Package for the segment translator: sizes, codes, entry record,
// controller states and the command/status structs. No dependencies.
`timescale 1ns / 1ps
package srat_pkg;

  localparam int MAX_SEG = 64;
  localparam int IDX_W   = $clog2(MAX_SEG);
  localparam int CNT_W   = $clog2(MAX_SEG + 1);
  localparam int PROBE   = 8;
  localparam int PROBE_W = $clog2(PROBE + 1);

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_FINALIZE = 2'd1,
    OP_LOOKUP   = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_MISS   = 2'd2,
    ST_NOTFIN = 2'd3
  } status_t;

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] offset;
    logic [63:0] length;
  } seg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_ADD,
    S_FRD, S_FCHK,
    S_SRD, S_SKEY, S_SCMP_RD, S_SCMP,
    S_LRD, S_LCHK, S_PROBE, S_PSUB, S_PCHK,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_I, RD_J_M1, RD_I_M1
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_KEPT, WR_COUNT, WR_J_KEY, WR_J_RDQ
  } wr_sel_t;

  typedef struct packed {
    logic    capture;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    i_clr;
    logic    i_one;
    logic    i_inc;
    logic    i_dec;
    logic    kept_clr;
    logic    kept_inc;
    logic    j_load;
    logic    j_dec;
    logic    step_clr;
    logic    step_inc;
    logic    key_load;
    logic    count_inc;
    logic    count_from_kept;
    logic    fin_set;
    logic    fin_clr;
    logic    into_load;
    logic    res_set;
    status_t res_code;
    logic    res_hit;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic add_bad;
    logic fin;
    logic look_miss;
    logic i_eq_count;
    logic j_zero;
    logic i_zero;
    logic step_done;
    logic fits;
    logic goes_before;
    logic start_le;
    logic hit;
    logic out_free;
  } flags_t;

endpackage

[hdl/srat_ctrl.sv]
// Controller FSM for the segment translator: sequences add, finalize
// (filter pass + insertion sort) and lookup. Uses srat_pkg.
`timescale 1ns / 1ps
module srat_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  srat_pkg::flags_t flags,
  output srat_pkg::cmd_t   cmd
);

  srat_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srat_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      srat_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = srat_pkg::S_DISPATCH;
        end
      end
      srat_pkg::S_DISPATCH: begin
        unique case (flags.op)
          srat_pkg::OP_ADD:      state_next = srat_pkg::S_ADD;
          srat_pkg::OP_FINALIZE: begin
            cmd.i_clr    = 1'b1;
            cmd.kept_clr = 1'b1;
            state_next   = srat_pkg::S_FRD;
          end
          srat_pkg::OP_LOOKUP: begin
            cmd.i_clr = 1'b1;
            if (!flags.fin) begin
              cmd.res_set  = 1'b1;
              cmd.res_code = srat_pkg::ST_NOTFIN;
              state_next   = srat_pkg::S_DONE;
            end else if (flags.look_miss) begin
              cmd.res_set  = 1'b1;
              cmd.res_code = srat_pkg::ST_MISS;
              state_next   = srat_pkg::S_DONE;
            end else begin
              state_next = srat_pkg::S_LRD;
            end
          end
          srat_pkg::OP_UNUSED: begin
            cmd.res_set  = 1'b1;
            cmd.res_code = srat_pkg::ST_REJECT;
            state_next   = srat_pkg::S_DONE;
          end
          default: state_next = srat_pkg::S_IDLE;
        endcase
      end
      srat_pkg::S_ADD: begin
        cmd.res_set = 1'b1;
        if (flags.add_bad) begin
          cmd.res_code = srat_pkg::ST_REJECT;
        end else begin
          cmd.res_code  = srat_pkg::ST_OK;
          cmd.wr_en     = 1'b1;
          cmd.wr_sel    = srat_pkg::WR_COUNT;
          cmd.count_inc = 1'b1;
          cmd.fin_clr   = 1'b1;
        end
        state_next = srat_pkg::S_DONE;
      end
      srat_pkg::S_FRD: begin
        if (flags.i_eq_count) begin
          cmd.count_from_kept = 1'b1;
          cmd.i_one           = 1'b1;
          state_next          = srat_pkg::S_SRD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = srat_pkg::RD_I;
          state_next = srat_pkg::S_FCHK;
        end
      end
      srat_pkg::S_FCHK: begin
        if (flags.fits) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_sel   = srat_pkg::WR_KEPT;
          cmd.kept_inc = 1'b1;
        end
        cmd.i_inc  = 1'b1;
        state_next = srat_pkg::S_FRD;
      end
      srat_pkg::S_SRD: begin
        // i runs from 1; an empty table also lands on i >= count here
        if (flags.i_eq_count || flags.i_zero) begin
          cmd.fin_set  = 1'b1;
          cmd.res_set  = 1'b1;
          cmd.res_code = srat_pkg::ST_OK;
          state_next   = srat_pkg::S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = srat_pkg::RD_I;
          cmd.j_load = 1'b1;
          state_next = srat_pkg::S_SKEY;
        end
      end
      srat_pkg::S_SKEY: begin
        cmd.key_load = 1'b1;
        state_next   = srat_pkg::S_SCMP_RD;
      end
      srat_pkg::S_SCMP_RD: begin
        if (flags.j_zero) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = srat_pkg::WR_J_KEY;
          cmd.i_inc  = 1'b1;
          state_next = srat_pkg::S_SRD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = srat_pkg::RD_J_M1;
          state_next = srat_pkg::S_SCMP;
        end
      end
      srat_pkg::S_SCMP: begin
        cmd.wr_en = 1'b1;
        if (flags.goes_before) begin
          cmd.wr_sel = srat_pkg::WR_J_KEY;
          cmd.i_inc  = 1'b1;
          state_next = srat_pkg::S_SRD;
        end else begin
          cmd.wr_sel = srat_pkg::WR_J_RDQ;
          cmd.j_dec  = 1'b1;
          state_next = srat_pkg::S_SCMP_RD;
        end
      end
      srat_pkg::S_LRD: begin
        cmd.step_clr = 1'b1;
        if (flags.i_eq_count) begin
          state_next = srat_pkg::S_PROBE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = srat_pkg::RD_I;
          state_next = srat_pkg::S_LCHK;
        end
      end
      srat_pkg::S_LCHK: begin
        cmd.step_clr = 1'b1;
        if (flags.start_le) begin
          cmd.i_inc  = 1'b1;
          state_next = srat_pkg::S_LRD;
        end else begin
          state_next = srat_pkg::S_PROBE;
        end
      end
      srat_pkg::S_PROBE: begin
        if (flags.step_done || flags.i_zero) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = srat_pkg::ST_MISS;
          state_next   = srat_pkg::S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = srat_pkg::RD_I_M1;
          cmd.i_dec  = 1'b1;
          state_next = srat_pkg::S_PSUB;
        end
      end
      srat_pkg::S_PSUB: begin
        cmd.into_load = 1'b1;
        state_next    = srat_pkg::S_PCHK;
      end
      srat_pkg::S_PCHK: begin
        if (flags.hit) begin
          cmd.res_hit = 1'b1;
          state_next  = srat_pkg::S_DONE;
        end else begin
          cmd.step_inc = 1'b1;
          state_next   = srat_pkg::S_PROBE;
        end
      end
      srat_pkg::S_DONE: begin
        if (flags.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = srat_pkg::S_IDLE;
        end
      end
      default: state_next = srat_pkg::S_IDLE;
    endcase
  end

endmodule

[hdl/srat_dp.sv]
// Datapath for the segment translator: segment memory, counters, compare
// logic and output register. Uses srat_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sorted_range_address_translator_defines.svh"
module srat_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       in_operation,
  input  logic [63:0]      in_virtual_address,
  input  logic [63:0]      in_file_offset,
  input  logic [63:0]      in_length,
  input  logic             cfg_write,
  input  logic [63:0]      cfg_data,
  input  srat_pkg::cmd_t   cmd,
  output srat_pkg::flags_t flags,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [63:0]      out_translated_offset,
  output logic [6:0]       out_entry_count
);

  localparam int IW = srat_pkg::IDX_W;
  localparam int CW = srat_pkg::CNT_W;

  srat_pkg::seg_t mem [srat_pkg::MAX_SEG];
  srat_pkg::seg_t rd_q, key, wr_data;
  logic [IW-1:0]  rd_addr, wr_addr;

  srat_pkg::op_t  op;
  logic [63:0]    addr, offs, len, file_size, into;
  logic [CW-1:0]  count, i, j, kept;
  logic [srat_pkg::PROBE_W-1:0] step;
  logic           fin;
  srat_pkg::status_t res_status;
  logic [63:0]    res_off;
  logic [64:0]    add_sum, look_sum;
  logic [63:0]    fs_room, seg_room;

  // read port
  always_comb begin
    unique case (cmd.rd_sel)
      srat_pkg::RD_I:    rd_addr = i[IW-1:0];
      srat_pkg::RD_J_M1: rd_addr = IW'(j - CW'(1));
      srat_pkg::RD_I_M1: rd_addr = IW'(i - CW'(1));
      default:           rd_addr = i[IW-1:0];
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      srat_pkg::WR_KEPT: begin
        wr_addr = kept[IW-1:0];
        wr_data = rd_q;
      end
      srat_pkg::WR_COUNT: begin
        wr_addr = count[IW-1:0];
        wr_data = '{start: addr, offset: offs, length: len};
      end
      srat_pkg::WR_J_KEY: begin
        wr_addr = j[IW-1:0];
        wr_data = key;
      end
      default: begin
        wr_addr = j[IW-1:0];
        wr_data = rd_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // payload, counter and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op   <= srat_pkg::op_t'(in_operation);
      addr <= in_virtual_address;
      offs <= in_file_offset;
      len  <= in_length;
    end
    if (cmd.key_load) key <= rd_q;
    if (cmd.into_load) into <= addr - rd_q.start;
    if (cmd.i_clr) i <= '0;
    else if (cmd.i_one) i <= CW'(1);
    else if (cmd.i_inc) i <= i + CW'(1);
    else if (cmd.i_dec) i <= i - CW'(1);
    if (cmd.kept_clr) kept <= '0;
    else if (cmd.kept_inc) kept <= kept + CW'(1);
    if (cmd.j_load) j <= i;
    else if (cmd.j_dec) j <= j - CW'(1);
    if (cmd.step_clr) step <= '0;
    else if (cmd.step_inc) step <= step + srat_pkg::PROBE_W'(1);
    if (cmd.res_set) begin
      res_status <= cmd.res_code;
      res_off    <= '0;
    end else if (cmd.res_hit) begin
      res_status <= srat_pkg::ST_OK;
      res_off    <= rd_q.offset + into;
    end
    if (cmd.out_load) begin
      out_status            <= res_status;
      out_translated_offset <= res_off;
      out_entry_count       <= 7'(count);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      fin       <= 1'b0;
      out_valid <= 1'b0;
      file_size <= '0;
    end else begin
      if (cfg_write) file_size <= cfg_data;
      if (cmd.count_inc) count <= count + CW'(1);
      else if (cmd.count_from_kept) count <= kept;
      if (cmd.fin_set) fin <= 1'b1;
      else if (cmd.fin_clr) fin <= 1'b0;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign add_sum  = {1'b0, addr} + {1'b0, len};
  assign look_sum = add_sum;
  assign fs_room  = file_size - rd_q.offset;
  assign seg_room = rd_q.length - into;

  always_comb begin
    flags.op          = op;
    flags.add_bad     = (len == '0) || (addr == '0) || add_sum[64] ||
                        (count == CW'(srat_pkg::MAX_SEG));
    flags.fin         = fin;
    flags.look_miss   = (count == '0) || (len == '0) || look_sum[64];
    // i only passes count when the sort starts at 1 on an empty table
    flags.i_eq_count  = (i >= count);
    flags.j_zero      = (j == '0);
    flags.i_zero      = (i == '0);
    flags.step_done   = (step == srat_pkg::PROBE_W'(srat_pkg::PROBE));
    flags.fits        = (rd_q.offset <= file_size) && (rd_q.length <= fs_room);
    flags.goes_before = (rd_q.start != key.start) ? (rd_q.start < key.start)
                                                  : (rd_q.length >= key.length);
    flags.start_le    = (rd_q.start <= addr);
    flags.hit         = (into < rd_q.length) && (seg_room >= len);
    flags.out_free    = !out_valid || out_ready;
  end

  `SRAT_ASSERT_NOW(a_count_range, 1'b1, count <= CW'(srat_pkg::MAX_SEG))
  `SRAT_ASSERT_NOW(a_add_room, cmd.count_inc, count < CW'(srat_pkg::MAX_SEG))
  `SRAT_ASSERT_NOW(a_compact_safe, cmd.wr_en && (cmd.wr_sel == srat_pkg::WR_KEPT), kept <= i)
  `SRAT_ASSERT_NOW(a_hit_finalized, cmd.res_hit, fin)
  `SRAT_ASSERT_NEXT(a_fin_set, cmd.fin_set, fin)

endmodule

[hdl/sorted_range_address_translator.sv]
// One item at a time, FSM-sequenced. A lookup ends at dispatch (not finalized, empty table,
// zero or wrapping request), else it scans the entries at or below the address and then runs
// up to 8 probes; finalize runs a filter pass over N entries, then an insertion sort with
// compares/shifts per sorted entry (O(N^2)).
// A finished result waits in the output register while the next item is accepted.
// Reset (rst, synchronous, high): table empty, not finalized, file_size zero, no result.
`timescale 1ns / 1ps
module sorted_range_address_translator (
  input  logic         clk,
  input  logic         rst,
  // config: file_size
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [63:0]  cfg_data,
  // input items
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,  // virtual_address[63:0], file_offset[127:64], length[191:128]
  input  logic [1:0]   s_tuser,  // operation[1:0]
  // result items
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata,  // translated_offset[63:0], entry_count[70:64], zero pad
  output logic [1:0]   m_tuser   // status[1:0]
);

  srat_pkg::cmd_t   cmd;
  srat_pkg::flags_t flags;
  logic [63:0]      out_off;
  logic [6:0]       out_cnt;

  // The user must write file_size only while idle; the block itself does not enforce it, so always take it
  assign cfg_ready = 1'b1;

  srat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .flags    (flags),
    .cmd      (cmd)
  );

  srat_dp u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .in_operation          (s_tuser),
    .in_virtual_address    (s_tdata[63:0]),
    .in_file_offset        (s_tdata[127:64]),
    .in_length             (s_tdata[191:128]),
    .cfg_write             (cfg_valid),
    .cfg_data              (cfg_data),
    .cmd                   (cmd),
    .flags                 (flags),
    .out_ready             (m_tready),
    .out_valid             (m_tvalid),
    .out_status            (m_tuser),
    .out_translated_offset (out_off),
    .out_entry_count       (out_cnt)
  );

  assign m_tdata = {1'b0, out_cnt, out_off};

endmodule
